/* sv/irs_pkg.sv */
// Shared types and constants for the inspection reject sequencer.
// Used by every module under sv/; no dependencies of its own.
package irs_pkg;

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_VERDICT = 2'd1,
		KIND_ANGLE   = 2'd2,
		KIND_SWEEP   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_AWAIT  = 3'd1,
		PH_PASS   = 3'd2,
		PH_RISE   = 3'd3,
		PH_HOLD   = 3'd4,
		PH_RETURN = 3'd5,
		PH_ALERT  = 3'd6
	} phase_t;

	typedef enum logic [3:0] {
		ACT_NONE      = 4'd0,
		ACT_NOTIFY    = 4'd1,
		ACT_SERVO     = 4'd2,
		ACT_RED_ON    = 4'd3,
		ACT_RED_OFF   = 4'd4,
		ACT_BUZ_ON    = 4'd5,
		ACT_BUZ_OFF   = 4'd6,
		ACT_GREEN_ON  = 4'd7,
		ACT_GREEN_OFF = 4'd8
	} act_t;

	typedef enum logic [2:0] {
		REG_MANUAL_MODE = 3'd0,
		REG_DEBOUNCE    = 3'd1,
		REG_TIMEOUT     = 3'd2,
		REG_REJECT_HOLD = 3'd3,
		REG_ALERT_HOLD  = 3'd4,
		REG_PASS_SIGNAL = 3'd5,
		REG_REJECT_ANG  = 3'd6,
		REG_REST_ANG    = 3'd7
	} reg_idx_t;

	localparam logic [1:0] ST_IDLE      = 2'd0;
	localparam logic [1:0] ST_AWAIT     = 2'd1;
	localparam logic [1:0] ST_PASSING   = 2'd2;
	localparam logic [1:0] ST_REJECTING = 2'd3;

	localparam logic [7:0] ANGLE_MAX = 8'd180;

	localparam int MAX_RES = 3;

	typedef struct packed {
		logic        manual_mode;
		logic [15:0] debounce_ms;
		logic [15:0] verdict_timeout_ms;
		logic [15:0] reject_hold_ms;
		logic [15:0] alert_hold_ms;
		logic [15:0] pass_signal_ms;
		logic [7:0]  reject_angle;
		logic [7:0]  rest_angle;
	} cfg_t;

	// One accepted event and all the result beats it causes.
	typedef struct packed {
		logic [1:0]              n_res;
		logic [MAX_RES-1:0][3:0] act;
		logic [MAX_RES-1:0][7:0] ang;
		logic [1:0]              status;
		logic                    seen;
		logic [31:0]             passes;
		logic [31:0]             rejects;
	} pkt_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* sv/irs_front.sv */
// Front end: accepts events, runs the sequencer state and builds one result packet.
// Depends on irs_pkg.
module irs_front #(
	parameter int REJECT_OUT_MS    = 300,
	parameter int REJECT_RETURN_MS = 300
) (
	input  logic               clk,
	input  logic               arst_n,
	input  irs_pkg::cfg_t      cfg,
	input  logic               accept,
	input  logic [1:0]         kind,
	input  logic [31:0]        now_ms,
	input  logic               sensor_present,
	input  logic               verdict_reject,
	input  logic signed [15:0] angle,
	output irs_pkg::pkt_t      pkt
);

	localparam logic [15:0] OUT_DUR = 16'(REJECT_OUT_MS);
	localparam logic [15:0] RET_DUR = 16'(REJECT_RETURN_MS);

	irs_pkg::phase_t phase_q, phase_n, ph_eff;
	logic        latched_q, latched_n;
	logic        wclr_q, wclr_n, wclr_tick;
	logic        level_q, level_n;
	logic        alerted_q, alerted_n;
	logic [31:0] deb_start_q, deb_start_n, deb_eff, deb_diff;
	logic [31:0] ph_start_q, ph_start_n, p_diff;
	logic [31:0] pass_q, pass_n, rej_q, rej_n;
	logic [15:0] dur;
	logic        is_tick, notify, elapsed;
	logic [7:0]  clamp_ang;

	assign is_tick   = irs_pkg::kind_t'(kind) == irs_pkg::KIND_TICK;
	assign deb_eff   = (sensor_present && !latched_q) ? now_ms : deb_start_q;
	assign deb_diff  = now_ms - deb_eff;
	assign wclr_tick = sensor_present ? wclr_q : 1'b0;
	assign notify    = is_tick && phase_q == irs_pkg::PH_IDLE && !wclr_tick && sensor_present
		&& deb_diff >= {16'd0, cfg.debounce_ms};
	assign ph_eff    = notify ? irs_pkg::PH_AWAIT : phase_q;
	assign p_diff    = notify ? 32'd0 : now_ms - ph_start_q;

	always_comb begin
		case (ph_eff)
			irs_pkg::PH_AWAIT:  dur = cfg.verdict_timeout_ms;
			irs_pkg::PH_RISE:   dur = OUT_DUR;
			irs_pkg::PH_HOLD:   dur = cfg.reject_hold_ms;
			irs_pkg::PH_RETURN: dur = RET_DUR;
			irs_pkg::PH_ALERT:  dur = cfg.alert_hold_ms;
			irs_pkg::PH_PASS:   dur = cfg.pass_signal_ms;
			default:            dur = 16'd0;
		endcase
	end

	assign elapsed = p_diff >= {16'd0, dur};

	always_comb begin
		if (angle[15])
			clamp_ang = 8'd0;
		else if (angle > $signed({8'd0, irs_pkg::ANGLE_MAX}))
			clamp_ang = irs_pkg::ANGLE_MAX;
		else
			clamp_ang = angle[7:0];
	end

	always_comb begin
		logic [1:0] idx;
		idx         = 2'd0;
		phase_n     = phase_q;
		latched_n   = latched_q;
		wclr_n      = wclr_q;
		level_n     = level_q;
		alerted_n   = alerted_q;
		deb_start_n = deb_start_q;
		ph_start_n  = ph_start_q;
		pass_n      = pass_q;
		rej_n       = rej_q;
		pkt         = '0;
		unique case (irs_pkg::kind_t'(kind))
			irs_pkg::KIND_TICK: begin
				level_n     = sensor_present;
				latched_n   = sensor_present;
				deb_start_n = deb_eff;
				wclr_n      = wclr_tick;
				if (notify) begin
					phase_n      = irs_pkg::PH_AWAIT;
					ph_start_n   = now_ms;
					wclr_n       = 1'b1;
					pkt.act[idx] = irs_pkg::ACT_NOTIFY;
					idx          = idx + 2'd1;
				end
				if (elapsed) begin
					case (ph_eff)
						irs_pkg::PH_AWAIT: begin
							pass_n       = pass_q + 32'd1;
							phase_n      = irs_pkg::PH_PASS;
							ph_start_n   = now_ms;
							pkt.act[idx] = irs_pkg::ACT_GREEN_ON;
							idx          = idx + 2'd1;
						end
						irs_pkg::PH_RISE: begin
							phase_n    = irs_pkg::PH_HOLD;
							ph_start_n = now_ms;
						end
						irs_pkg::PH_HOLD: begin
							phase_n      = irs_pkg::PH_RETURN;
							ph_start_n   = now_ms;
							pkt.act[idx] = irs_pkg::ACT_SERVO;
							pkt.ang[idx] = cfg.rest_angle;
							idx          = idx + 2'd1;
						end
						irs_pkg::PH_RETURN: begin
							phase_n = irs_pkg::PH_IDLE;
							wclr_n  = 1'b1;
							if (alerted_q) begin
								pkt.act[idx] = irs_pkg::ACT_RED_OFF;
								idx          = idx + 2'd1;
								pkt.act[idx] = irs_pkg::ACT_BUZ_OFF;
								idx          = idx + 2'd1;
								alerted_n    = 1'b0;
							end
						end
						irs_pkg::PH_ALERT: begin
							phase_n      = irs_pkg::PH_IDLE;
							wclr_n       = 1'b1;
							pkt.act[idx] = irs_pkg::ACT_RED_OFF;
							idx          = idx + 2'd1;
							pkt.act[idx] = irs_pkg::ACT_BUZ_OFF;
							idx          = idx + 2'd1;
						end
						irs_pkg::PH_PASS: begin
							phase_n      = irs_pkg::PH_IDLE;
							wclr_n       = 1'b1;
							pkt.act[idx] = irs_pkg::ACT_GREEN_OFF;
							idx          = idx + 2'd1;
						end
						default: ;
					endcase
				end
			end
			irs_pkg::KIND_VERDICT: begin
				if (phase_q == irs_pkg::PH_AWAIT) begin
					ph_start_n = now_ms;
					if (!verdict_reject) begin
						pass_n       = pass_q + 32'd1;
						phase_n      = irs_pkg::PH_PASS;
						pkt.act[idx] = irs_pkg::ACT_GREEN_ON;
						idx          = idx + 2'd1;
					end else begin
						rej_n = rej_q + 32'd1;
						if (!cfg.manual_mode) begin
							alerted_n    = 1'b1;
							phase_n      = irs_pkg::PH_RISE;
							pkt.act[idx] = irs_pkg::ACT_SERVO;
							pkt.ang[idx] = cfg.reject_angle;
							idx          = idx + 2'd1;
						end else begin
							phase_n = irs_pkg::PH_ALERT;
						end
						pkt.act[idx] = irs_pkg::ACT_RED_ON;
						idx          = idx + 2'd1;
						pkt.act[idx] = irs_pkg::ACT_BUZ_ON;
						idx          = idx + 2'd1;
					end
				end
			end
			irs_pkg::KIND_ANGLE: begin
				if (cfg.manual_mode && phase_q == irs_pkg::PH_IDLE) begin
					pkt.act[idx] = irs_pkg::ACT_SERVO;
					pkt.ang[idx] = clamp_ang;
					idx          = idx + 2'd1;
				end
			end
			irs_pkg::KIND_SWEEP: begin
				if (cfg.manual_mode && phase_q == irs_pkg::PH_IDLE) begin
					alerted_n    = 1'b0;
					phase_n      = irs_pkg::PH_RISE;
					ph_start_n   = now_ms;
					pkt.act[idx] = irs_pkg::ACT_SERVO;
					pkt.ang[idx] = cfg.reject_angle;
					idx          = idx + 2'd1;
				end
			end
			default: ;
		endcase
		// an event with no action still yields one beat
		pkt.n_res = (idx == 2'd0) ? 2'd1 : idx;
		case (phase_n)
			irs_pkg::PH_IDLE:  pkt.status = irs_pkg::ST_IDLE;
			irs_pkg::PH_AWAIT: pkt.status = irs_pkg::ST_AWAIT;
			irs_pkg::PH_PASS:  pkt.status = irs_pkg::ST_PASSING;
			default:           pkt.status = irs_pkg::ST_REJECTING;
		endcase
		pkt.seen    = level_n;
		pkt.passes  = pass_n;
		pkt.rejects = rej_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= irs_pkg::PH_IDLE;
			latched_q   <= 1'b0;
			wclr_q      <= 1'b0;
			level_q     <= 1'b0;
			alerted_q   <= 1'b0;
			deb_start_q <= '0;
			ph_start_q  <= '0;
			pass_q      <= '0;
			rej_q       <= '0;
		end else if (accept) begin
			phase_q     <= phase_n;
			latched_q   <= latched_n;
			wclr_q      <= wclr_n;
			level_q     <= level_n;
			alerted_q   <= alerted_n;
			deb_start_q <= deb_start_n;
			ph_start_q  <= ph_start_n;
			pass_q      <= pass_n;
			rej_q       <= rej_n;
		end
	end

endmodule

/* sv/irs_fifo.sv */
// Short packet queue between the front end and the result sequencer.
// Depends on irs_pkg.
module irs_fifo #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  irs_pkg::pkt_t     wr_pkt,
	input  logic              pop,
	output irs_pkg::pkt_t     head,
	output irs_pkg::q_stat_t  stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	irs_pkg::pkt_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign stat.full  = cnt_q == CW'(DEPTH);
	assign stat.empty = cnt_q == '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_pkt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count above depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full && !pop))
		else $error("push into full queue");

endmodule

/* sv/irs_back.sv */
// Back end: walks the head packet and sends its result beats one per cycle while m_tready is high.
// Depends on irs_pkg.
module irs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  irs_pkg::pkt_t     head,
	input  irs_pkg::q_stat_t  stat,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [79:0]       m_tdata,
	output logic [3:0]        m_tuser,
	output logic              m_tlast
);

	logic [1:0] idx_q;
	logic       beat;

	assign m_tvalid = !stat.empty;
	assign m_tlast  = idx_q == head.n_res - 2'd1;
	assign beat     = m_tvalid && m_tready;
	assign pop      = beat && m_tlast;
	assign m_tuser  = head.act[idx_q];
	assign m_tdata  = {5'd0, head.rejects, head.passes, head.seen, head.status,
		head.ang[idx_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (beat)
			idx_q <= m_tlast ? 2'd0 : idx_q + 2'd1;
	end

	a_idx_in_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (head.n_res != 2'd0) && (idx_q < head.n_res))
		else $error("beat index outside packet");

	a_pkt_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(beat && !m_tlast) |=> m_tvalid)
		else $error("packet dropped before last beat");

endmodule

/* sv/inspection_reject_sequencer_core.sv */
// Top level of the inspection reject sequencer: register file, front end,
// packet queue and result sequencer. Depends on irs_pkg, irs_front, irs_fifo, irs_back.
//
// Channel   Dir  Beat holds
// -------   ---  -------------------------------------------------------------
// s_*       in   one event: tuser kind, tdata now_ms/sensor/verdict/angle
// m_*       out  one result: tuser action, tdata angle/status/counts, tlast
// APB       in   register writes and reads, 5-bit byte address, 32-bit data
//
// Flow: an event is taken and queued as a packet of one to three result beats;
// the result side sends one beat a cycle while m_tready is high, so single-result
// events can be sustained at one event per cycle; events with more beats are
// limited by the output beat rate of the result sequencer.
// Reset: arst_n clears sequencer state, counters, queue and registers to defaults.
// Stalls: s_tready drops only when the packet queue is full; m_tready low holds
// the current beat while the front end keeps filling the queue.
module inspection_reject_sequencer_core #(
	parameter int REJECT_OUT_MS    = 300,
	parameter int REJECT_RETURN_MS = 300,
	parameter int QUEUE_DEPTH      = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: now_ms[31:0], sensor_present[32], verdict_reject[33], angle[49:34]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,
	// s_tuser: kind[1:0]
	input  logic [1:0]  s_tuser,
	// m_tdata: servo_angle[7:0], unit_status[9:8], item_seen[10],
	//          passes[42:11], rejects[74:43]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,
	// m_tuser: action[3:0]
	output logic [3:0]  m_tuser,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	irs_pkg::cfg_t     cfg_q;
	irs_pkg::pkt_t     new_pkt, head_pkt;
	irs_pkg::q_stat_t  q_stat;
	logic              accept, pop, wr_en;
	irs_pkg::reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = irs_pkg::reg_idx_t'(paddr[4:2]);

	// Register file: user rule, written only while the block is idle, so no shadowing; not enforced by the block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.manual_mode        <= 1'b0;
			cfg_q.debounce_ms        <= 16'd50;
			cfg_q.verdict_timeout_ms <= 16'd2000;
			cfg_q.reject_hold_ms     <= 16'd500;
			cfg_q.alert_hold_ms      <= 16'd1000;
			cfg_q.pass_signal_ms     <= 16'd500;
			cfg_q.reject_angle       <= 8'd90;
			cfg_q.rest_angle         <= 8'd0;
		end else if (wr_en) begin
			unique case (reg_idx)
				irs_pkg::REG_MANUAL_MODE: cfg_q.manual_mode        <= pwdata[0];
				irs_pkg::REG_DEBOUNCE:    cfg_q.debounce_ms        <= pwdata[15:0];
				irs_pkg::REG_TIMEOUT:     cfg_q.verdict_timeout_ms <= pwdata[15:0];
				irs_pkg::REG_REJECT_HOLD: cfg_q.reject_hold_ms     <= pwdata[15:0];
				irs_pkg::REG_ALERT_HOLD:  cfg_q.alert_hold_ms      <= pwdata[15:0];
				irs_pkg::REG_PASS_SIGNAL: cfg_q.pass_signal_ms     <= pwdata[15:0];
				irs_pkg::REG_REJECT_ANG:  cfg_q.reject_angle       <= pwdata[7:0];
				irs_pkg::REG_REST_ANG:    cfg_q.rest_angle         <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back: zero-extend each register to the bus width.
	always_comb begin
		unique case (reg_idx)
			irs_pkg::REG_MANUAL_MODE: prdata = {31'd0, cfg_q.manual_mode};
			irs_pkg::REG_DEBOUNCE:    prdata = {16'd0, cfg_q.debounce_ms};
			irs_pkg::REG_TIMEOUT:     prdata = {16'd0, cfg_q.verdict_timeout_ms};
			irs_pkg::REG_REJECT_HOLD: prdata = {16'd0, cfg_q.reject_hold_ms};
			irs_pkg::REG_ALERT_HOLD:  prdata = {16'd0, cfg_q.alert_hold_ms};
			irs_pkg::REG_PASS_SIGNAL: prdata = {16'd0, cfg_q.pass_signal_ms};
			irs_pkg::REG_REJECT_ANG:  prdata = {24'd0, cfg_q.reject_angle};
			irs_pkg::REG_REST_ANG:    prdata = {24'd0, cfg_q.rest_angle};
			default:                  prdata = 32'd0;
		endcase
	end

	// Take an event whenever the queue has room; the packet lands the same edge.
	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	irs_front #(
		.REJECT_OUT_MS    (REJECT_OUT_MS),
		.REJECT_RETURN_MS (REJECT_RETURN_MS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.accept         (accept),
		.kind           (s_tuser),
		.now_ms         (s_tdata[31:0]),
		.sensor_present (s_tdata[32]),
		.verdict_reject (s_tdata[33]),
		.angle          (s_tdata[49:34]),
		.pkt            (new_pkt)
	);

	irs_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wr_pkt (new_pkt),
		.pop    (pop),
		.head   (head_pkt),
		.stat   (q_stat)
	);

	// Drain the head packet beat by beat; pop it on its last beat.
	irs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head_pkt),
		.stat     (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* tb/sv/irs_result_checker.sv */
// Result checker for the inspection reject sequencer: mirrors register writes,
// predicts the result beats of every accepted event and compares them in order.
// Depends on irs_pkg for the event kinds, phases, actions and register indexes.
module irs_result_checker #(
	parameter int REJECT_OUT_MS    = 300,
	parameter int REJECT_RETURN_MS = 300
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// s_tdata: now_ms[31:0], sensor_present[32], verdict_reject[33], angle[49:34]
	input  logic [55:0] s_tdata,
	// s_tuser: kind[1:0]
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: servo_angle[7:0], unit_status[9:8], item_seen[10],
	//          passes[42:11], rejects[74:43]
	input  logic [79:0] m_tdata,
	// m_tuser: action[3:0]
	input  logic [3:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		irs_pkg::act_t act;
		logic [7:0]    angle;
		logic          last;
		logic [1:0]    status;
		logic          seen;
		logic [31:0]   passes;
		logic [31:0]   rejects;
	} result_beat_t;

	result_beat_t due_q[$];
	int           fail_tally = 0;

	// mirrored registers and sequencer state
	irs_pkg::cfg_t   regs;
	irs_pkg::phase_t unit_phase;
	logic            sensor_armed, need_clear, level_seen, alarm_raised;
	logic [31:0]     debounce_t0, phase_t0, pass_count, reject_count;

	irs_pkg::act_t   pend_act[irs_pkg::MAX_RES];
	logic [7:0]      pend_ang[irs_pkg::MAX_RES];
	int              pend_n;

	function automatic logic run_out(input logic [31:0] now, input logic [31:0] start,
		input logic [31:0] span);
		return (now - start) >= span;
	endfunction

	task automatic stage_action(input irs_pkg::act_t act, input logic [7:0] ang);
		if (pend_n < irs_pkg::MAX_RES) begin
			pend_act[pend_n] = act;
			pend_ang[pend_n] = ang;
			pend_n++;
		end
	endtask

	task automatic start_green(input logic [31:0] now);
		pass_count = pass_count + 32'd1;
		unit_phase = irs_pkg::PH_PASS;
		phase_t0 = now;
		stage_action(irs_pkg::ACT_GREEN_ON, 8'd0);
	endtask

	task automatic predict_event(input irs_pkg::kind_t kind, input logic [31:0] now,
		input logic present, input logic reject, input logic signed [15:0] req_angle);
		result_beat_t b;
		logic [1:0]   st;
		logic [7:0]   clamped;
		pend_n = 0;
		case (kind)
			irs_pkg::KIND_TICK: begin
				level_seen = present;
				if (present && !sensor_armed) begin
					sensor_armed = 1'b1;
					debounce_t0 = now;
				end else if (!present) begin
					sensor_armed = 1'b0;
					need_clear = 1'b0;
				end
				if (unit_phase == irs_pkg::PH_IDLE && !need_clear && sensor_armed &&
					run_out(now, debounce_t0, 32'(regs.debounce_ms))) begin
					unit_phase = irs_pkg::PH_AWAIT;
					phase_t0 = now;
					need_clear = 1'b1;
					stage_action(irs_pkg::ACT_NOTIFY, 8'd0);
				end
				case (unit_phase)
					irs_pkg::PH_AWAIT: begin
						if (run_out(now, phase_t0, 32'(regs.verdict_timeout_ms)))
							start_green(now);
					end
					irs_pkg::PH_RISE: begin
						if (run_out(now, phase_t0, 32'(REJECT_OUT_MS))) begin
							unit_phase = irs_pkg::PH_HOLD;
							phase_t0 = now;
						end
					end
					irs_pkg::PH_HOLD: begin
						if (run_out(now, phase_t0, 32'(regs.reject_hold_ms))) begin
							unit_phase = irs_pkg::PH_RETURN;
							phase_t0 = now;
							stage_action(irs_pkg::ACT_SERVO, regs.rest_angle);
						end
					end
					irs_pkg::PH_RETURN: begin
						if (run_out(now, phase_t0, 32'(REJECT_RETURN_MS))) begin
							unit_phase = irs_pkg::PH_IDLE;
							need_clear = 1'b1;
							if (alarm_raised) begin
								stage_action(irs_pkg::ACT_RED_OFF, 8'd0);
								stage_action(irs_pkg::ACT_BUZ_OFF, 8'd0);
								alarm_raised = 1'b0;
							end
						end
					end
					irs_pkg::PH_ALERT: begin
						if (run_out(now, phase_t0, 32'(regs.alert_hold_ms))) begin
							unit_phase = irs_pkg::PH_IDLE;
							need_clear = 1'b1;
							stage_action(irs_pkg::ACT_RED_OFF, 8'd0);
							stage_action(irs_pkg::ACT_BUZ_OFF, 8'd0);
						end
					end
					irs_pkg::PH_PASS: begin
						if (run_out(now, phase_t0, 32'(regs.pass_signal_ms))) begin
							unit_phase = irs_pkg::PH_IDLE;
							need_clear = 1'b1;
							stage_action(irs_pkg::ACT_GREEN_OFF, 8'd0);
						end
					end
					default: ;
				endcase
			end
			irs_pkg::KIND_VERDICT: begin
				if (unit_phase == irs_pkg::PH_AWAIT) begin
					if (!reject) begin
						start_green(now);
					end else begin
						reject_count = reject_count + 32'd1;
						phase_t0 = now;
						if (!regs.manual_mode) begin
							alarm_raised = 1'b1;
							unit_phase = irs_pkg::PH_RISE;
							stage_action(irs_pkg::ACT_SERVO, regs.reject_angle);
						end else begin
							unit_phase = irs_pkg::PH_ALERT;
						end
						stage_action(irs_pkg::ACT_RED_ON, 8'd0);
						stage_action(irs_pkg::ACT_BUZ_ON, 8'd0);
					end
				end
			end
			default: begin
				// manual requests only count in manual mode with the line idle
				if (regs.manual_mode && unit_phase == irs_pkg::PH_IDLE) begin
					if (kind == irs_pkg::KIND_ANGLE) begin
						if (req_angle < 0)
							clamped = 8'd0;
						else if (req_angle > $signed({8'd0, irs_pkg::ANGLE_MAX}))
							clamped = irs_pkg::ANGLE_MAX;
						else
							clamped = req_angle[7:0];
						stage_action(irs_pkg::ACT_SERVO, clamped);
					end else begin
						alarm_raised = 1'b0;
						unit_phase = irs_pkg::PH_RISE;
						phase_t0 = now;
						stage_action(irs_pkg::ACT_SERVO, regs.reject_angle);
					end
				end
			end
		endcase
		if (pend_n == 0)
			stage_action(irs_pkg::ACT_NONE, 8'd0);

		case (unit_phase)
			irs_pkg::PH_IDLE:  st = irs_pkg::ST_IDLE;
			irs_pkg::PH_AWAIT: st = irs_pkg::ST_AWAIT;
			irs_pkg::PH_PASS:  st = irs_pkg::ST_PASSING;
			default:           st = irs_pkg::ST_REJECTING;
		endcase
		for (int k = 0; k < pend_n; k++) begin
			b.act = pend_act[k];
			b.angle = pend_ang[k];
			b.last = (k == pend_n - 1);
			b.status = st;
			b.seen = level_seen;
			b.passes = pass_count;
			b.rejects = reject_count;
			due_q.push_back(b);
		end
	endtask

	task automatic compare_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			fail_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_beat_t want;
		if (!arst_n) begin
			regs = '{1'b0, 16'd50, 16'd2000, 16'd500, 16'd1000, 16'd500, 8'd90, 8'd0};
			unit_phase = irs_pkg::PH_IDLE;
			sensor_armed = 1'b0;
			need_clear = 1'b0;
			level_seen = 1'b0;
			alarm_raised = 1'b0;
			debounce_t0 = '0;
			phase_t0 = '0;
			pass_count = '0;
			reject_count = '0;
			due_q.delete();
			errors <= fail_tally;
			outstanding <= 0;
		end else begin
			// check the outgoing beat first: it cannot stem from an event taken now
			if (m_tvalid && m_tready) begin
				if (due_q.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual action %0h",
						$time, m_tuser);
					fail_tally++;
				end else begin
					want = due_q.pop_front();
					compare_field("action", 32'(want.act), 32'(m_tuser));
					compare_field("servo_angle", 32'(want.angle), 32'(m_tdata[7:0]));
					compare_field("last", 32'(want.last), 32'(m_tlast));
					compare_field("unit_status", 32'(want.status), 32'(m_tdata[9:8]));
					compare_field("item_seen", 32'(want.seen), 32'(m_tdata[10]));
					compare_field("passes", want.passes, m_tdata[42:11]);
					compare_field("rejects", want.rejects, m_tdata[74:43]);
				end
			end
			// an event taken at this edge still sees the old register values
			if (s_tvalid && s_tready)
				predict_event(irs_pkg::kind_t'(s_tuser), s_tdata[31:0], s_tdata[32],
					s_tdata[33], s_tdata[49:34]);
			if (psel && penable && pwrite && pready) begin
				case (irs_pkg::reg_idx_t'(paddr[4:2]))
					irs_pkg::REG_MANUAL_MODE: regs.manual_mode = pwdata[0];
					irs_pkg::REG_DEBOUNCE:    regs.debounce_ms = pwdata[15:0];
					irs_pkg::REG_TIMEOUT:     regs.verdict_timeout_ms = pwdata[15:0];
					irs_pkg::REG_REJECT_HOLD: regs.reject_hold_ms = pwdata[15:0];
					irs_pkg::REG_ALERT_HOLD:  regs.alert_hold_ms = pwdata[15:0];
					irs_pkg::REG_PASS_SIGNAL: regs.pass_signal_ms = pwdata[15:0];
					irs_pkg::REG_REJECT_ANG:  regs.reject_angle = pwdata[7:0];
					irs_pkg::REG_REST_ANG:    regs.rest_angle = pwdata[7:0];
					default: ;
				endcase
			end
			errors <= fail_tally;
			outstanding <= due_q.size();
		end
	end

endmodule

/* tb/sv/tb_inspection_reject_sequencer_core.sv */
// Testbench top for inspection_reject_sequencer_core: clock, reset, event stimulus,
// register writes over APB and a stalling result sink. Depends on irs_pkg and
// irs_result_checker, which predicts and compares every result beat.
module tb_inspection_reject_sequencer_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;  // cycles with no beat and no APB access
	localparam int LONG_HOLD   = 300;   // receiver hold-off that fills the queue

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          errors;
	int          outstanding;

	logic [31:0] clock_ms;      // event timestamp, advanced by each offered event
	logic        line_sensor;   // sensor level the random traffic follows
	bit          calm = 1'b0;   // when set, neither side adds random idles

	inspection_reject_sequencer_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	irs_result_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one event beat. Advance the timestamp by dt, idle a random number of
	// cycles first, then hold tvalid until the block takes the beat. tvalid stays
	// high afterwards so back-to-back beats need no extra assignment.
	task automatic offer_event(input irs_pkg::kind_t kind, input logic [31:0] dt,
		input logic present, input logic reject, input logic [15:0] ang);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		clock_ms = clock_ms + dt;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {6'd0, ang, reject, present, clock_ms};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop tvalid and wait until every predicted beat has come out.
	task automatic wait_quiet();
		@(negedge clk);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the write lands when pready is seen high.
	task automatic apb_write(input irs_pkg::reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_settings(input irs_pkg::cfg_t c);
		apb_write(irs_pkg::REG_MANUAL_MODE, 32'(c.manual_mode));
		apb_write(irs_pkg::REG_DEBOUNCE, 32'(c.debounce_ms));
		apb_write(irs_pkg::REG_TIMEOUT, 32'(c.verdict_timeout_ms));
		apb_write(irs_pkg::REG_REJECT_HOLD, 32'(c.reject_hold_ms));
		apb_write(irs_pkg::REG_ALERT_HOLD, 32'(c.alert_hold_ms));
		apb_write(irs_pkg::REG_PASS_SIGNAL, 32'(c.pass_signal_ms));
		apb_write(irs_pkg::REG_REJECT_ANG, 32'(c.reject_angle));
		apb_write(irs_pkg::REG_REST_ANG, 32'(c.rest_angle));
	endtask

	// Mostly sensor ticks that follow a slowly toggling item sensor with time steps
	// scaled to the current durations, so items get debounced, judged and sequenced.
	// Mix in verdicts, manual requests, big time jumps and sensor glitches as noise.
	// Fields an event kind ignores still carry random values.
	task automatic mixed_traffic(input int count, input int step_max);
		irs_pkg::kind_t k;
		logic [31:0]    dt;
		logic           pres;
		logic           rej;
		logic [15:0]    ang;
		int             r;
		for (int i = 0; i < count; i++) begin
			if (i % 30 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) == 0)
				line_sensor = ~line_sensor;
			dt = $urandom_range(0, step_max);
			pres = 1'($urandom_range(0, 1));
			rej = 1'($urandom_range(0, 1));
			ang = 16'($urandom);
			r = $urandom_range(0, 99);
			if (r < 62) begin
				k = irs_pkg::KIND_TICK;
				pres = line_sensor;
			end else if (r < 77) begin
				k = irs_pkg::KIND_VERDICT;
			end else if (r < 86) begin
				k = irs_pkg::KIND_ANGLE;
				// keep four of nine requests in -5 to 185, just around the clamp range
				if (r < 81)
					ang = 16'($urandom_range(0, 190)) - 16'd5;
			end else if (r < 91) begin
				k = irs_pkg::KIND_SWEEP;
			end else if (r < 96) begin
				k = irs_pkg::KIND_TICK;
				pres = line_sensor;
				dt = $urandom;
			end else begin
				// glitch: random level at the same timestamp
				k = irs_pkg::KIND_TICK;
				dt = '0;
			end
			offer_event(k, dt, pres, rej, ang);
		end
		calm = 1'b0;
	endtask

	// Result sink: stall a random number of cycles before each beat, and twice
	// hold off for a long stretch so the queue fills and s_tready drops.
	initial begin : result_sink
		int hold;
		int taken;
		taken = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken == 150 || taken == 600)
				hold = LONG_HOLD;
			else
				hold = calm ? 0 : $urandom_range(0, 14);
			if (hold > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_inspection_reject_sequencer_core: FAIL");
		$finish;
	end

	initial begin : stimulus
		irs_pkg::cfg_t c;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		line_sensor = 1'b0;
		arst_n = 1'b0;
		// start just short of the wrap so the directed run crosses zero
		clock_ms = 32'hFFFF_FF00;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, on reset settings: automatic mode, debounce 50, timeout 2000,
		// hold 500, pass 500, reject angle 90, rest angle 0.
		offer_event(irs_pkg::KIND_VERDICT, 32'd255, 1'b0, 1'b1, 16'h0000); // ignored
		offer_event(irs_pkg::KIND_ANGLE, 32'd1, 1'b0, 1'b0, 16'h8000);     // auto, ignored
		offer_event(irs_pkg::KIND_SWEEP, 32'd0, 1'b0, 1'b0, 16'h7FFF);     // ignored
		offer_event(irs_pkg::KIND_TICK, 32'd10, 1'b1, 1'b0, 16'h0000);     // latch sensor
		offer_event(irs_pkg::KIND_TICK, 32'd50, 1'b1, 1'b0, 16'h0000);     // notify
		offer_event(irs_pkg::KIND_VERDICT, 32'd40, 1'b0, 1'b1, 16'h0000);  // servo out
		offer_event(irs_pkg::KIND_TICK, 32'd300, 1'b1, 1'b0, 16'h0000);    // into hold
		offer_event(irs_pkg::KIND_TICK, 32'd500, 1'b1, 1'b0, 16'h0000);    // servo to rest
		offer_event(irs_pkg::KIND_TICK, 32'd300, 1'b1, 1'b0, 16'h0000);    // red, buzzer off
		offer_event(irs_pkg::KIND_TICK, 32'd100, 1'b1, 1'b0, 16'h0000);    // same item
		offer_event(irs_pkg::KIND_TICK, 32'd100, 1'b0, 1'b0, 16'h0000);    // item gone
		offer_event(irs_pkg::KIND_TICK, 32'd100, 1'b1, 1'b0, 16'h0000);
		offer_event(irs_pkg::KIND_TICK, 32'd50, 1'b1, 1'b0, 16'h0000);     // notify
		offer_event(irs_pkg::KIND_VERDICT, 32'd50, 1'b0, 1'b0, 16'h0000);  // green on
		offer_event(irs_pkg::KIND_TICK, 32'd500, 1'b0, 1'b0, 16'h0000);    // green off
		offer_event(irs_pkg::KIND_TICK, 32'd100, 1'b1, 1'b0, 16'h0000);
		offer_event(irs_pkg::KIND_TICK, 32'd50, 1'b1, 1'b0, 16'h0000);     // no notify: clear pending
		offer_event(irs_pkg::KIND_TICK, 32'd2000, 1'b1, 1'b0, 16'h0000);   // idle, no default pass
		offer_event(irs_pkg::KIND_TICK, 32'd500, 1'b0, 1'b0, 16'h0000);    // item gone, idle

		// Directed, manual mode: angle clamping and sweep; the sensor clear left by the sweep blocks the next item.
		wait_quiet();
		apb_write(irs_pkg::REG_MANUAL_MODE, 32'd1);
		offer_event(irs_pkg::KIND_ANGLE, 32'd1, 1'b0, 1'b0, 16'h7FFF);     // clamps to 180
		offer_event(irs_pkg::KIND_ANGLE, 32'd1, 1'b0, 1'b0, 16'hFFFF);     // clamps to 0
		offer_event(irs_pkg::KIND_SWEEP, 32'd1, 1'b0, 1'b0, 16'h0000);     // no lights
		offer_event(irs_pkg::KIND_TICK, 32'd300, 1'b0, 1'b0, 16'h0000);
		offer_event(irs_pkg::KIND_TICK, 32'd500, 1'b0, 1'b0, 16'h0000);    // servo to rest
		offer_event(irs_pkg::KIND_TICK, 32'd300, 1'b0, 1'b0, 16'h0000);    // idle, quiet
		offer_event(irs_pkg::KIND_TICK, 32'd10, 1'b1, 1'b0, 16'h0000);
		offer_event(irs_pkg::KIND_TICK, 32'd50, 1'b1, 1'b0, 16'h0000);     // no notify: clear pending
		offer_event(irs_pkg::KIND_VERDICT, 32'd10, 1'b0, 1'b1, 16'h0000);  // ignored: not awaiting
		offer_event(irs_pkg::KIND_TICK, 32'd1000, 1'b0, 1'b0, 16'h0000);   // no alert to end

		// Random phases; registers change only between them, with the block drained.
		wait_quiet();
		load_settings('{1'b0, 16'd20, 16'd100, 16'd60, 16'd80, 16'd50, 8'd90, 8'd0});
		mixed_traffic(70, 40);

		wait_quiet();
		load_settings('{1'b1, 16'd30, 16'd120, 16'd40, 16'd90, 16'd60, 8'd180, 8'd0});
		mixed_traffic(70, 50);

		// zero register durations: the verdict timeout elapses on the notifying tick itself
		wait_quiet();
		load_settings('{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd180});
		mixed_traffic(70, 400);

		// longest durations
		wait_quiet();
		load_settings('{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			8'd180, 8'd0});
		mixed_traffic(70, 40000);

		for (int p = 0; p < 2; p++) begin
			wait_quiet();
			c.manual_mode = 1'($urandom_range(0, 1));
			c.debounce_ms = 16'($urandom_range(0, 400));
			c.verdict_timeout_ms = 16'($urandom_range(0, 400));
			c.reject_hold_ms = 16'($urandom_range(0, 400));
			c.alert_hold_ms = 16'($urandom_range(0, 400));
			c.pass_signal_ms = 16'($urandom_range(0, 400));
			c.reject_angle = 8'($urandom_range(0, 180));
			c.rest_angle = 8'($urandom_range(0, 180));
			load_settings(c);
			mixed_traffic(60, 150);
		end

		wait_quiet();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_inspection_reject_sequencer_core: PASS");
		else
			$display("tb_inspection_reject_sequencer_core: FAIL");
		$finish;
	end

endmodule
